>>> rtl/amortization_with_prepayment_assert.svh
// Assertion macros shared by the amortization RTL.
`ifndef AMORTIZATION_WITH_PREPAYMENT_ASSERT_SVH
`define AMORTIZATION_WITH_PREPAYMENT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AWP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define AWP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AWP_ASSERT_IMP(label, clk, rst, ante, cons)
`define AWP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/awp_pkg.sv
// Types and constants of the amortization block.
`timescale 1ns / 1ps
package awp_pkg;
   localparam int MONEY_BITS = 48;
   localparam int RATE_BITS  = 32;
   localparam int TERM_BITS  = 10;
   localparam int WIDE_BITS  = 64;
   localparam int HALF_BITS  = WIDE_BITS / 2;
   localparam int RSP_BITS   = 240;

   typedef logic [WIDE_BITS-1:0]   wide_type;
   typedef logic [2*WIDE_BITS-1:0] dwide_type;
   typedef logic [MONEY_BITS-1:0]  money_type;
   typedef logic [RATE_BITS-1:0]   rate_type;
   typedef logic [TERM_BITS-1:0]   term_type;

   localparam logic [1:0] CSR_PRINCIPAL = 2'd0;
   localparam logic [1:0] CSR_RATE      = 2'd1;
   localparam logic [1:0] CSR_TERM      = 2'd2;

   localparam rate_type  Q31_ONE    = rate_type'(64'h8000_0000);
   localparam wide_type  Q62_ONE    = 64'h4000_0000_0000_0000;
   localparam wide_type  Q60_ONE    = 64'h1000_0000_0000_0000;
   localparam money_type MONEY_MAX  = '1;
   localparam term_type  TERM_RESET = term_type'(360);
   // floor(x / 12) for any 32-bit x is (x * DIV12_MUL) >> 35
   localparam wide_type  DIV12_MUL  = 64'h0000_0000_AAAA_AAAB;
endpackage

>>> rtl/amortization_with_prepayment.sv
// Top level: sequencer of the amortization schedule over a shared multiplier and divider.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: prepay_cpr; tuser: restart
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: period .. cpr_used; tlast: schedule_end
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// A period's time is set by 31 root steps of four products each on the shared
// multiplier; a zero CPR skips the root. A restart adds one product for the
// monthly rate, two divider passes (one when the monthly rate is zero) and up
// to 21 products for the power and numerator.
// Reset is synchronous and clears control state. req is taken only between items;
// a finished result waits in the output register and a new item may be taken then.
`timescale 1ns / 1ps
`include "amortization_with_prepayment_assert.svh"
module amortization_with_prepayment (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] prepay_cpr
   input  logic [0:0]   req_tuser,   // [0] restart
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [9:0] period_number, [57:10] level_payment, [105:58] interest_due,
   // [153:106] principal_paid, [201:154] balance_after, [233:202] cpr_used
   output logic [239:0] rsp_tdata,
   output logic         rsp_tlast,   // schedule_end
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [47:0]  csr_data
);
   import awp_pkg::*;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_MR    = 5'd1;
   localparam logic [4:0] ST_LOAD  = 5'd2;
   localparam logic [4:0] ST_PAYZ  = 5'd3;
   localparam logic [4:0] ST_VDIV  = 5'd4;
   localparam logic [4:0] ST_POW   = 5'd5;
   localparam logic [4:0] ST_POWG  = 5'd6;
   localparam logic [4:0] ST_POWB  = 5'd7;
   localparam logic [4:0] ST_PRM   = 5'd8;
   localparam logic [4:0] ST_PRD   = 5'd9;
   localparam logic [4:0] ST_CHK   = 5'd10;
   localparam logic [4:0] ST_INT   = 5'd11;
   localparam logic [4:0] ST_SMM0  = 5'd12;
   localparam logic [4:0] ST_P2    = 5'd13;
   localparam logic [4:0] ST_P3    = 5'd14;
   localparam logic [4:0] ST_P6    = 5'd15;
   localparam logic [4:0] ST_P12   = 5'd16;
   localparam logic [4:0] ST_PRE   = 5'd17;
   localparam logic [4:0] ST_SCHED = 5'd18;
   localparam logic [4:0] ST_OUT   = 5'd19;

   // Configuration and schedule state
   money_type prin_ff, bal_ff, pay_ff, int_ff, pre_ff, sch_ff;
   rate_type  yrate_ff, mrate_ff, cpr_ff, y_ff, pw_ff;
   term_type  term_ff, pcnt_ff, n_ff;
   logic      active_ff, busy_ff, restart_ff;
   logic [4:0] state_ff;
   logic [4:0] bit_ff;
   wide_type  g_ff, b_ff;

   // Output register
   logic        rsp_valid_ff, rsp_last_ff;
   logic [RSP_BITS-1:0] rsp_data_ff;

   // Shared units
   logic      mul_start, div_start, mul_done, div_done;
   wide_type  mul_a, mul_b, div_hi, div_lo, div_d, div_q;
   dwide_type mul_prod;

   awp_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .prod (mul_prod)
   );

   awp_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .hi (div_hi), .lo (div_lo), .d (div_d), .done (div_done), .q (div_q)
   );

   rate_type  trial, cpr_clamped;
   wide_type  rate_q62, y12;
   money_type rem_bal, pre_cl, total, new_bal;
   term_type  pcnt_next;
   logic      last;

   // Period arithmetic and trial root value
   always_comb begin
      trial       = y_ff | (rate_type'(1) << bit_ff);
      cpr_clamped = (req_tdata > Q31_ONE) ? Q31_ONE : req_tdata;
      rate_q62    = {1'b0, mrate_ff, 31'd0};
      y12         = mul_prod[94:31];
      rem_bal     = bal_ff - sch_ff;
      pre_cl      = (pre_ff < rem_bal) ? pre_ff : rem_bal;
      total       = sch_ff + pre_cl;
      new_bal     = rem_bal - pre_cl;
      pcnt_next   = pcnt_ff + term_type'(1);
      last        = (new_bal == '0) || (pcnt_next >= term_ff);
   end

   // Operand selection for the shared units
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      div_hi = '0;
      div_lo = '0;
      div_d  = wide_type'(1);
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff) inside
         ST_MR: begin
            mul_a = wide_type'(yrate_ff);
            mul_b = DIV12_MUL;
            mul_start = !busy_ff;
         end
         ST_PAYZ: begin
            div_lo = wide_type'(bal_ff);
            div_d  = wide_type'(term_ff);
            div_start = !busy_ff;
         end
         ST_VDIV: begin
            div_hi = Q60_ONE;
            div_d  = Q62_ONE + rate_q62;
            div_start = !busy_ff;
         end
         ST_POWG: begin
            mul_a = g_ff;
            mul_b = b_ff;
            mul_start = !busy_ff;
         end
         ST_POWB: begin
            mul_a = b_ff;
            mul_b = b_ff;
            mul_start = !busy_ff;
         end
         ST_PRM: begin
            mul_a = wide_type'(bal_ff);
            mul_b = rate_q62;
            mul_start = !busy_ff;
         end
         ST_PRD: begin
            div_hi = mul_prod[127:64];
            div_lo = mul_prod[63:0];
            div_d  = Q62_ONE - g_ff;
            div_start = !busy_ff;
         end
         ST_INT: begin
            mul_a = wide_type'(bal_ff);
            mul_b = wide_type'(mrate_ff);
            mul_start = !busy_ff;
         end
         ST_P2: begin
            mul_a = wide_type'(trial);
            mul_b = wide_type'(trial);
            mul_start = !busy_ff;
         end
         ST_P3: begin
            mul_a = wide_type'(pw_ff);
            mul_b = wide_type'(trial);
            mul_start = !busy_ff;
         end
         ST_P6, ST_P12: begin
            mul_a = wide_type'(pw_ff);
            mul_b = wide_type'(pw_ff);
            mul_start = !busy_ff;
         end
         ST_PRE: begin
            mul_a = wide_type'(bal_ff);
            mul_b = wide_type'(Q31_ONE - y_ff);
            mul_start = !busy_ff;
         end
         default: begin
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prin_ff  <= '0;
         yrate_ff <= '0;
         term_ff  <= TERM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PRINCIPAL: prin_ff  <= csr_data;
            CSR_RATE:      yrate_ff <= csr_data[RATE_BITS-1:0];
            CSR_TERM:      term_ff  <= csr_data[TERM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         active_ff    <= 1'b0;
         bal_ff       <= '0;
         pcnt_ff      <= '0;
         pay_ff       <= '0;
         mrate_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mul_start || div_start) begin
            busy_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= req_tuser[0] ? ST_MR : ST_CHK;
               end
            end
            ST_MR: begin
               if (busy_ff && mul_done) begin
                  busy_ff   <= 1'b0;
                  mrate_ff  <= mul_prod[66:35];
                  bal_ff    <= prin_ff;
                  pcnt_ff   <= '0;
                  pay_ff    <= '0;
                  active_ff <= 1'b0;
                  state_ff  <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               if (term_ff == '0 || bal_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else if (mrate_ff == '0) begin
                  state_ff <= ST_PAYZ;
               end else begin
                  state_ff <= ST_VDIV;
               end
            end
            ST_PAYZ: begin
               if (busy_ff && div_done) begin
                  busy_ff   <= 1'b0;
                  pay_ff    <= div_q[MONEY_BITS-1:0];
                  active_ff <= 1'b1;
                  state_ff  <= ST_CHK;
               end
            end
            ST_VDIV: begin
               if (busy_ff && div_done) begin
                  busy_ff  <= 1'b0;
                  b_ff     <= div_q;
                  g_ff     <= Q62_ONE;
                  n_ff     <= term_ff;
                  state_ff <= ST_POW;
               end
            end
            ST_POW: begin
               if (n_ff == '0) begin
                  state_ff <= ST_PRM;
               end else begin
                  state_ff <= n_ff[0] ? ST_POWG : ST_POWB;
               end
            end
            ST_POWG: begin
               if (busy_ff && mul_done) begin
                  busy_ff  <= 1'b0;
                  g_ff     <= mul_prod[125:62];
                  state_ff <= ST_POWB;
               end
            end
            ST_POWB: begin
               if (busy_ff && mul_done) begin
                  busy_ff  <= 1'b0;
                  b_ff     <= mul_prod[125:62];
                  n_ff     <= n_ff >> 1;
                  state_ff <= ST_POW;
               end
            end
            ST_PRM: begin
               if (busy_ff && mul_done) begin
                  busy_ff  <= 1'b0;
                  state_ff <= ST_PRD;
               end
            end
            ST_PRD: begin
               if (busy_ff && div_done) begin
                  busy_ff   <= 1'b0;
                  pay_ff    <= (div_q > wide_type'(MONEY_MAX)) ? MONEY_MAX
                                                            : div_q[MONEY_BITS-1:0];
                  active_ff <= 1'b1;
                  state_ff  <= ST_CHK;
               end
            end
            ST_CHK: begin
               if (!active_ff || bal_ff == '0 || term_ff == '0 || pcnt_ff >= term_ff) begin
                  active_ff <= 1'b0;
                  state_ff  <= ST_IDLE;
               end else begin
                  state_ff <= ST_INT;
               end
            end
            ST_INT: begin
               if (busy_ff && mul_done) begin
                  busy_ff  <= 1'b0;
                  int_ff   <= mul_prod[78:31];
                  state_ff <= ST_SMM0;
               end
            end
            ST_SMM0: begin
               if (cpr_ff == '0) begin
                  y_ff     <= Q31_ONE;
                  state_ff <= ST_PRE;
               end else begin
                  y_ff     <= '0;
                  bit_ff   <= 5'd30;
                  state_ff <= ST_P2;
               end
            end
            ST_P2: begin
               if (busy_ff && mul_done) begin
                  busy_ff  <= 1'b0;
                  pw_ff    <= mul_prod[62:31];
                  state_ff <= ST_P3;
               end
            end
            ST_P3: begin
               if (busy_ff && mul_done) begin
                  busy_ff  <= 1'b0;
                  pw_ff    <= mul_prod[62:31];
                  state_ff <= ST_P6;
               end
            end
            ST_P6: begin
               if (busy_ff && mul_done) begin
                  busy_ff  <= 1'b0;
                  pw_ff    <= mul_prod[62:31];
                  state_ff <= ST_P12;
               end
            end
            ST_P12: begin
               if (busy_ff && mul_done) begin
                  busy_ff <= 1'b0;
                  if (y12 <= wide_type'(Q31_ONE - cpr_ff)) begin
                     y_ff <= trial;
                  end
                  if (bit_ff == '0) begin
                     state_ff <= ST_PRE;
                  end else begin
                     bit_ff   <= bit_ff - 5'd1;
                     state_ff <= ST_P2;
                  end
               end
            end
            ST_PRE: begin
               if (busy_ff && mul_done) begin
                  busy_ff  <= 1'b0;
                  pre_ff   <= mul_prod[78:31];
                  state_ff <= ST_SCHED;
               end
            end
            ST_SCHED: begin
               if (pay_ff <= int_ff) begin
                  sch_ff <= '0;
               end else if (pay_ff - int_ff > bal_ff) begin
                  sch_ff <= bal_ff;
               end else begin
                  sch_ff <= pay_ff - int_ff;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // Hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  bal_ff       <= new_bal;
                  pcnt_ff      <= pcnt_next;
                  if (last) begin
                     active_ff <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Payload captures
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         cpr_ff     <= cpr_clamped;
         restart_ff <= req_tuser[0];
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {6'd0, cpr_ff, new_bal, total, int_ff, pay_ff, pcnt_next};
         rsp_last_ff <= last;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `AWP_ASSERT_IMP(a_active_balance, clock, reset, active_ff, bal_ff != '0)
   `AWP_ASSERT_IMP(a_restart_path, clock, reset, state_ff == ST_LOAD, restart_ff)
endmodule

>>> rtl/awp_mul.sv
// Shared 64x64 multiplier built from one 32x32 multiplier applied to four partial products in turn.
`timescale 1ns / 1ps
`include "amortization_with_prepayment_assert.svh"
module awp_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  awp_pkg::wide_type  a,
   input  awp_pkg::wide_type  b,
   output logic               done,
   output awp_pkg::dwide_type prod
);
   import awp_pkg::*;

   wide_type  a_ff, b_ff;
   dwide_type acc_ff;
   logic [1:0] step_ff;
   logic       run_ff, done_ff;
   logic [HALF_BITS-1:0] a_half, b_half;
   wide_type  pp;
   logic [1:0] sh;
   dwide_type pp_sh;

   // Select halves and align the partial product
   always_comb begin
      a_half = step_ff[1] ? a_ff[WIDE_BITS-1:HALF_BITS] : a_ff[HALF_BITS-1:0];
      b_half = step_ff[0] ? b_ff[WIDE_BITS-1:HALF_BITS] : b_ff[HALF_BITS-1:0];
      pp     = wide_type'(a_half) * wide_type'(b_half);
      sh     = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
      pp_sh  = dwide_type'(pp) << (32'(sh) * 32'(HALF_BITS));
   end

   // Sequence the four partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Latch operands and accumulate
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (run_ff) begin
         acc_ff <= acc_ff + pp_sh;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

   `AWP_ASSERT_IMP(a_mul_no_restart, clock, reset, start, !run_ff)
endmodule

>>> rtl/awp_div.sv
// Shared restoring divider, 128 by 64 bits, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "amortization_with_prepayment_assert.svh"
module awp_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  awp_pkg::wide_type hi,
   input  awp_pkg::wide_type lo,
   input  awp_pkg::wide_type d,
   output logic              done,
   output awp_pkg::wide_type q
);
   import awp_pkg::*;

   wide_type rem_ff, lo_ff, q_ff, d_ff;
   logic [5:0] cnt_ff;
   logic run_ff, done_ff;
   logic carry, take;
   wide_type shifted;

   // One restoring step
   always_comb begin
      carry   = rem_ff[WIDE_BITS-1];
      shifted = {rem_ff[WIDE_BITS-2:0], lo_ff[WIDE_BITS-1]};
      take    = carry || (shifted >= d_ff);
   end

   // Control: saturate at once when the quotient overflows
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= '0;
            if (hi >= d) begin
               done_ff <= 1'b1;
            end else begin
               run_ff <= 1'b1;
            end
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= hi;
         lo_ff  <= lo;
         d_ff   <= d;
         q_ff   <= (hi >= d) ? '1 : '0;
      end else if (run_ff) begin
         rem_ff <= take ? shifted - d_ff : shifted;
         lo_ff  <= {lo_ff[WIDE_BITS-2:0], 1'b0};
         q_ff   <= {q_ff[WIDE_BITS-2:0], take};
      end
   end

   assign done = done_ff;
   assign q    = q_ff;

   `AWP_ASSERT_NXT(a_div_done_idle, clock, reset, done_ff, !run_ff)
endmodule
